// ===== rtl/core/graph_depth_first_walk_top_macros.svh =====
// ---------------------------------------------------------------------------
// Graph walk assertion macros
// Short forms for the concurrent checks of the graph walk core. Each use
// samples on clk and is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef GRAPH_DEPTH_FIRST_WALK_TOP_MACROS_SVH
`define GRAPH_DEPTH_FIRST_WALK_TOP_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define GDFW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gdfw: same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define GDFW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gdfw: next-cycle check failed");

`endif

// ===== rtl/core/gdfw_pkg.sv =====
// ---------------------------------------------------------------------------
// Graph walk package
// Fixed field widths, mode codes and the vertex range check.
// ---------------------------------------------------------------------------
package gdfw_pkg;

  localparam int VTX_W = 6;
  localparam int CFG_W = 7;

  localparam logic [CFG_W-1:0] NV_RESET = 7'd64;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_WALK = 1'b1;

  // A vertex is live when below the configured count and the built size.
  function automatic logic vtx_ok(input logic [VTX_W-1:0] v,
                                  input logic [CFG_W-1:0] nv,
                                  input int unsigned      maxv);
    logic below_cfg;
    logic below_max;
    below_cfg = (CFG_W'(v) < nv);
    below_max = (32'(v) < maxv);
    return below_cfg && below_max;
  endfunction

endpackage

// ===== rtl/core/gdfw_ram.sv =====
// ---------------------------------------------------------------------------
// Graph walk RAM
// Simple dual-port RAM, one write port with bit mask, one registered read.
// ---------------------------------------------------------------------------
module gdfw_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [WIDTH-1:0]  wmask,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask[i]) begin
          mem[waddr][i] <= wdata[i];
        end
      end
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/graph_depth_first_walk_top.sv =====
// ---------------------------------------------------------------------------
// Graph depth-first walk
// Directed graph held as per-vertex neighbor lists, with an iterative
// depth-first walk. A mode 0 transaction inserts src -> dst at the head of
// the source's list; it is dropped silently when an endpoint is not below
// num_vertices or the edge store is full. A mode 1 transaction walks from
// src and returns one result transaction per vertex reached, in first-visit
// order, with last set on the final one; a bad start vertex gives nothing.
// Lists, visited marks and the walk stack sit in two RAMs, so a walk is
// serialized on their ports: it clears the visited mark of every vertex
// slot, then pops stack entries, dropping a vertex out of range or already
// visited; each vertex expanded is marked, queued for output and has its
// list scanned edge by edge, an unvisited target in range being pushed
// while the stack has room; it closes by releasing the final result. A
// stalled result register holds the walk in place until it drains. After
// reset the block runs a clearing pass over every vertex RAM entry and holds
// in_stall high until it ends; cfg writes are taken at any time.
// ---------------------------------------------------------------------------
`include "graph_depth_first_walk_top_macros.svh"

module graph_depth_first_walk_top #(
  parameter int VERTEX_SLOTS = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gdfw_pkg::CFG_W-1:0] cfg_num_vertices,
  // input transactions
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_mode,
  input  logic [gdfw_pkg::VTX_W-1:0] in_src_vertex,
  input  logic [gdfw_pkg::VTX_W-1:0] in_dst_vertex,
  // result transactions
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [gdfw_pkg::VTX_W-1:0] out_visited_vertex,
  output logic                       out_last
);

  import gdfw_pkg::*;

  // Edge index also carries the empty-list marker MAX_EDGES.
  localparam int EW          = $clog2(MAX_EDGES + 1);
  localparam int STACK_DEPTH = MAX_EDGES + 1;
  localparam int SPW         = $clog2(MAX_EDGES + 2);
  localparam int VAW         = $clog2(VERTEX_SLOTS);
  localparam int VMW         = EW + 1;
  localparam int EMW         = 2 * VTX_W + EW;

  localparam logic [EW-1:0]  EMPTY_LINK = EW'(MAX_EDGES);
  localparam logic [VAW-1:0] LAST_VTX   = VAW'(VERTEX_SLOTS - 1);

  // Vertex word: {seen, head}. Edge word: {stack slot, link, target}.
  localparam logic [VMW-1:0] SEEN_MASK = {1'b1, {EW{1'b0}}};
  localparam logic [VMW-1:0] HEAD_MASK = {1'b0, {EW{1'b1}}};
  localparam logic [EMW-1:0] STK_MASK  = {{VTX_W{1'b1}}, {(EW + VTX_W){1'b0}}};
  localparam logic [EMW-1:0] EDGE_MASK = {{VTX_W{1'b0}}, {(EW + VTX_W){1'b1}}};

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ADD   = 4'd2;
  localparam logic [3:0] S_CLR   = 4'd3;
  localparam logic [3:0] S_POP   = 4'd4;
  localparam logic [3:0] S_POPR  = 4'd5;
  localparam logic [3:0] S_VRD   = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;
  localparam logic [3:0] S_EDGE  = 4'd8;
  localparam logic [3:0] S_EDGER = 4'd9;
  localparam logic [3:0] S_TCHK  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0]       state_r,    state_nxt;
  logic [CFG_W-1:0] nv_r;
  logic [EW-1:0]    edge_cnt_r, edge_cnt_nxt;
  logic [SPW-1:0]   sp_r,       sp_nxt;
  logic [VAW-1:0]   clr_r,      clr_nxt;
  logic [VTX_W-1:0] src_r,      src_nxt;
  logic [VTX_W-1:0] dst_r,      dst_nxt;
  logic [VTX_W-1:0] v_r,        v_nxt;
  logic [VTX_W-1:0] t_r,        t_nxt;
  logic [EW-1:0]    e_r,        e_nxt;
  logic             pend_r,     pend_nxt;
  logic [VTX_W-1:0] pend_v_r,   pend_v_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VTX_W-1:0] out_vtx_r,   out_vtx_nxt;
  logic             out_last_r,  out_last_nxt;

  logic             vm_we;
  logic [VMW-1:0]   vm_wmask, vm_wdata, vm_rdata;
  logic [VAW-1:0]   vm_waddr, vm_raddr;
  logic             em_we;
  logic [EMW-1:0]   em_wmask, em_wdata, em_rdata;
  logic [EW-1:0]    em_waddr, em_raddr;

  logic             out_free;
  logic [SPW-1:0]   sp_m1;
  logic [VTX_W-1:0] em_stk, em_tgt;
  logic [EW-1:0]    em_link;
  logic             vm_seen;
  logic [EW-1:0]    vm_head;

  // Vertex RAM: list head and visited mark per vertex.
  gdfw_ram #(
    .WIDTH (VMW),
    .DEPTH (VERTEX_SLOTS)
  ) u_vtx_ram (
    .clk   (clk),
    .we    (vm_we),
    .wmask (vm_wmask),
    .waddr (vm_waddr),
    .wdata (vm_wdata),
    .raddr (vm_raddr),
    .rdata (vm_rdata)
  );

  // Edge RAM: edge target and link, plus one walk stack slot per entry.
  gdfw_ram #(
    .WIDTH (EMW),
    .DEPTH (STACK_DEPTH)
  ) u_edge_ram (
    .clk   (clk),
    .we    (em_we),
    .wmask (em_wmask),
    .waddr (em_waddr),
    .wdata (em_wdata),
    .raddr (em_raddr),
    .rdata (em_rdata)
  );

  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_visited_vertex = out_vtx_r;
  assign out_last           = out_last_r;

  // The result register can take a new transaction when empty or draining.
  assign out_free = !out_valid_r || !out_stall;

  assign sp_m1   = sp_r - SPW'(1);
  assign em_tgt  = em_rdata[VTX_W-1:0];
  assign em_link = em_rdata[VTX_W+EW-1:VTX_W];
  assign em_stk  = em_rdata[EMW-1:VTX_W+EW];
  assign vm_seen = vm_rdata[EW];
  assign vm_head = vm_rdata[EW-1:0];

  // Sequencer. Every RAM read is issued in the state before its use and no
  // state reads an entry written at the same edge, so no forwarding path is
  // needed.
  always_comb begin
    state_nxt     = state_r;
    edge_cnt_nxt  = edge_cnt_r;
    sp_nxt        = sp_r;
    clr_nxt       = clr_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    v_nxt         = v_r;
    t_nxt         = t_r;
    e_nxt         = e_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_vtx_nxt   = out_vtx_r;
    out_last_nxt  = out_last_r;
    in_stall      = 1'b1;

    vm_we    = 1'b0;
    vm_wmask = '0;
    vm_waddr = clr_r;
    vm_wdata = '0;
    vm_raddr = VAW'(in_src_vertex);
    em_we    = 1'b0;
    em_wmask = '0;
    em_waddr = sp_r[EW-1:0];
    em_wdata = '0;
    em_raddr = e_r;

    unique case (state_r)
      S_INIT: begin
        // Post-reset pass: every list empty.
        vm_we    = 1'b1;
        vm_wmask = '1;
        vm_wdata = {1'b0, EMPTY_LINK};
        if (clr_r == LAST_VTX) begin
          clr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + VAW'(1);
        end
      end

      S_IDLE: begin
        // Head of the source list is read at the accepting edge.
        in_stall = 1'b0;
        if (in_valid) begin
          src_nxt = in_src_vertex;
          dst_nxt = in_dst_vertex;
          if (in_mode == MODE_ADD) begin
            if (vtx_ok(in_src_vertex, nv_r, VERTEX_SLOTS) &&
                vtx_ok(in_dst_vertex, nv_r, VERTEX_SLOTS) &&
                (edge_cnt_r < EMPTY_LINK)) begin
              state_nxt = S_ADD;
            end
          end else begin
            if (vtx_ok(in_src_vertex, nv_r, VERTEX_SLOTS)) begin
              state_nxt = S_CLR;
            end
          end
        end
      end

      S_ADD: begin
        // Link the new edge in front of the old head.
        em_we     = 1'b1;
        em_wmask  = EDGE_MASK;
        em_waddr  = edge_cnt_r;
        em_wdata  = {{VTX_W{1'b0}}, vm_head, dst_r};
        vm_we     = 1'b1;
        vm_wmask  = HEAD_MASK;
        vm_waddr  = VAW'(src_r);
        vm_wdata  = {1'b0, edge_cnt_r};
        edge_cnt_nxt = edge_cnt_r + EW'(1);
        state_nxt = S_IDLE;
      end

      S_CLR: begin
        // Clear visited marks, then push the start vertex.
        vm_we    = 1'b1;
        vm_wmask = SEEN_MASK;
        vm_wdata = '0;
        if (clr_r == LAST_VTX) begin
          clr_nxt   = '0;
          em_we     = 1'b1;
          em_wmask  = STK_MASK;
          em_waddr  = '0;
          em_wdata  = {src_r, {(EW + VTX_W){1'b0}}};
          sp_nxt    = SPW'(1);
          pend_nxt  = 1'b0;
          state_nxt = S_POP;
        end else begin
          clr_nxt = clr_r + VAW'(1);
        end
      end

      S_POP: begin
        if (sp_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          em_raddr  = sp_m1[EW-1:0];
          sp_nxt    = sp_m1;
          state_nxt = S_POPR;
        end
      end

      S_POPR: begin
        v_nxt    = em_stk;
        vm_raddr = VAW'(em_stk);
        if (vtx_ok(em_stk, nv_r, VERTEX_SLOTS)) begin
          state_nxt = S_VRD;
        end else begin
          state_nxt = S_POP;
        end
      end

      S_VRD: begin
        // Drop vertices reached earlier; otherwise mark and expand.
        if (vm_seen) begin
          state_nxt = S_POP;
        end else begin
          vm_we     = 1'b1;
          vm_wmask  = SEEN_MASK;
          vm_waddr  = VAW'(v_r);
          vm_wdata  = {1'b1, {EW{1'b0}}};
          e_nxt     = vm_head;
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        // Hold one vertex back so the final one can carry last.
        if (!pend_r || out_free) begin
          if (pend_r) begin
            out_valid_nxt = 1'b1;
            out_vtx_nxt   = pend_v_r;
            out_last_nxt  = 1'b0;
          end
          pend_nxt   = 1'b1;
          pend_v_nxt = v_r;
          state_nxt  = S_EDGE;
        end
      end

      S_EDGE: begin
        if (e_r < edge_cnt_r) begin
          em_raddr  = e_r;
          state_nxt = S_EDGER;
        end else begin
          state_nxt = S_POP;
        end
      end

      S_EDGER: begin
        e_nxt    = em_link;
        t_nxt    = em_tgt;
        vm_raddr = VAW'(em_tgt);
        if (vtx_ok(em_tgt, nv_r, VERTEX_SLOTS)) begin
          state_nxt = S_TCHK;
        end else begin
          state_nxt = S_EDGE;
        end
      end

      S_TCHK: begin
        // Push unvisited neighbors only.
        if (!vm_seen && (sp_r < SPW'(STACK_DEPTH))) begin
          em_we    = 1'b1;
          em_wmask = STK_MASK;
          em_waddr = sp_r[EW-1:0];
          em_wdata = {t_r, {(EW + VTX_W){1'b0}}};
          sp_nxt   = sp_r + SPW'(1);
        end
        state_nxt = S_EDGE;
      end

      S_FIN: begin
        // Release the held vertex as the final result.
        if (!pend_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_vtx_nxt   = pend_v_r;
          out_last_nxt  = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      nv_r        <= NV_RESET;
      edge_cnt_r  <= '0;
      sp_r        <= '0;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      sp_r        <= sp_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        nv_r <= cfg_num_vertices;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    v_r        <= v_nxt;
    t_r        <= t_nxt;
    e_r        <= e_nxt;
    pend_v_r   <= pend_v_nxt;
    out_vtx_r  <= out_vtx_nxt;
    out_last_r <= out_last_nxt;
  end

  `GDFW_ASSERT_IMP(a_sp_bound, state_r != S_INIT, sp_r <= SPW'(STACK_DEPTH))
  `GDFW_ASSERT_IMP(a_idle_no_pend, state_r == S_IDLE, !pend_r)
  `GDFW_ASSERT_NXT(a_cnt_hold, state_r != S_ADD, edge_cnt_r == $past(edge_cnt_r))
  `GDFW_ASSERT_NXT(a_walk_start, state_r == S_IDLE && in_valid && in_mode == MODE_WALK && vtx_ok(in_src_vertex, nv_r, VERTEX_SLOTS), state_r == S_CLR)
  `GDFW_ASSERT_NXT(a_fin_last, state_r == S_FIN && pend_r && out_free, out_valid_r && out_last_r)

endmodule

// ===== verif/tb_graph_depth_first_walk_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Graph depth-first walk testbench
// Builds directed graphs through edge-insert transactions and runs walks
// from many start vertices under several vertex counts. A predictor keeps
// its own copy of the neighbor lists and computes the first-visit order of
// each walk; every result transaction is checked against the oldest
// predicted visit. Both channels idle and stall at random, the receiver
// holds off once for a long stretch, and the edge store is driven full.
// ---------------------------------------------------------------------------
module tb_graph_depth_first_walk_top;
  import gdfw_pkg::*;

  localparam int VERTEX_SLOTS  = 64;
  localparam int MAX_EDGES     = 256;
  localparam int STACK_DEPTH   = MAX_EDGES + 1;
  localparam int CLK_HALF      = 5;
  // Cycles to let an edge insert or a silent walk finish before a cfg write.
  localparam int SETTLE_CYCLES = 24;
  // A full-graph walk can scan every edge between two results; allow far more.
  localparam int STALL_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_PCT      = 38;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             last;
  } visit_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_num_vertices;
  logic             in_valid;
  logic             in_stall;
  logic             in_mode;
  logic [VTX_W-1:0] in_src_vertex;
  logic [VTX_W-1:0] in_dst_vertex;
  logic             out_valid;
  logic             out_stall;
  logic [VTX_W-1:0] out_visited_vertex;
  logic             out_last;

  // Predictor state: neighbor lists run newest first through edge_next.
  logic [8:0]       edge_head [VERTEX_SLOTS];
  logic [VTX_W-1:0] edge_dst  [MAX_EDGES];
  logic [8:0]       edge_next [MAX_EDGES];
  int unsigned      edge_total;
  logic [CFG_W-1:0] vertex_count_cfg;

  visit_t expected_visits [$];
  int     fail_count;
  bit     no_idle;
  int     hold_off_left;

  graph_depth_first_walk_top #(
    .VERTEX_SLOTS (VERTEX_SLOTS),
    .MAX_EDGES    (MAX_EDGES)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_num_vertices   (cfg_num_vertices),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_src_vertex      (in_src_vertex),
    .in_dst_vertex      (in_dst_vertex),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_visited_vertex (out_visited_vertex),
    .out_last           (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  // Counts above the built size act as the built size.
  function automatic int unsigned live_vertices();
    return (vertex_count_cfg > VERTEX_SLOTS) ? VERTEX_SLOTS : vertex_count_cfg;
  endfunction

  function automatic void predict_walk(input logic [VTX_W-1:0] start);
    int unsigned      lim;
    int unsigned      depth;
    int unsigned      e;
    logic [VTX_W-1:0] v;
    logic [VTX_W-1:0] t;
    bit               seen [VERTEX_SLOTS];
    logic [VTX_W-1:0] stack [STACK_DEPTH];
    visit_t           order [$];
    lim = live_vertices();
    if (start >= lim) return;
    seen = '{default: 1'b0};
    stack[0] = start;
    depth = 1;
    while (depth > 0) begin
      depth--;
      v = stack[depth];
      // Skip a vertex already reached through another path; do not expand again.
      if (v >= lim || seen[v]) continue;
      seen[v] = 1'b1;
      order.push_back('{vertex: v, last: 1'b0});
      e = edge_head[v];
      while (e < edge_total) begin
        t = edge_dst[e];
        // Skip targets beyond a shrunk vertex count.
        if (t < lim && !seen[t] && depth < STACK_DEPTH) begin
          stack[depth] = t;
          depth++;
        end
        e = edge_next[e];
      end
    end
    order[order.size() - 1].last = 1'b1;
    foreach (order[i]) expected_visits.push_back(order[i]);
  endfunction

  function automatic void predict_item(input logic mode, input logic [VTX_W-1:0] src,
                                       input logic [VTX_W-1:0] dst);
    int unsigned lim;
    lim = live_vertices();
    if (mode == MODE_WALK) begin
      predict_walk(src);
    end else if (src < lim && dst < lim && edge_total < MAX_EDGES) begin
      // Insert at the head of the source list; drop out-of-range or overflow edges.
      edge_dst[edge_total]  = dst;
      edge_next[edge_total] = edge_head[src];
      edge_head[src]        = 9'(edge_total);
      edge_total++;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------

  // Offer one transaction from a falling edge; return at the falling edge
  // after it is taken, with valid still high.
  task automatic send_item(input logic mode, input logic [VTX_W-1:0] src,
                           input logic [VTX_W-1:0] dst);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_mode       = mode;
    in_src_vertex = src;
    in_dst_vertex = dst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(mode, src, dst);
    @(negedge clk);
  endtask

  // Drop valid, drain every predicted visit, then let a silent item finish.
  task automatic wait_quiet();
    in_valid = 1'b0;
    while (expected_visits.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_vertex_count(input logic [CFG_W-1:0] count);
    wait_quiet();
    cfg_valid        = 1'b1;
    cfg_num_vertices = count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    vertex_count_cfg = count;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly in-range edges and walks, with some full-range noise.
  task automatic send_random_item();
    int unsigned      lim;
    int unsigned      roll;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    lim  = (live_vertices() == 0) ? 1 : live_vertices();
    roll = $urandom_range(0, 99);
    a    = VTX_W'($urandom_range(0, lim - 1));
    b    = VTX_W'($urandom_range(0, lim - 1));
    if (roll < 65) begin
      send_item(MODE_ADD, a, b);
    end else if (roll < 78) begin
      send_item(MODE_ADD, VTX_W'($urandom_range(0, 63)), VTX_W'($urandom_range(0, 63)));
    end else if (roll < 95) begin
      send_item(MODE_WALK, a, VTX_W'($urandom_range(0, 63)));
    end else begin
      send_item(MODE_WALK, VTX_W'($urandom_range(0, 63)), VTX_W'($urandom_range(0, 63)));
    end
  endtask

  // Receiver: a requested hold-off wins, otherwise stall at random.
  initial begin
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_stall = 1'b1;
        hold_off_left--;
      end else begin
        out_stall = !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result checking
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : visit_check
    visit_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_visits.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result: vertex %0d last %0b", out_visited_vertex, out_last);
      end else begin
        want = expected_visits.pop_front();
        if (out_visited_vertex !== want.vertex || out_last !== want.last) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("result mismatch: expected vertex %0d last %0b, got vertex %0d last %0b",
                     want.vertex, want.last, out_visited_vertex, out_last);
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("graph_depth_first_walk_top: mismatch");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Small graph with a cycle, a self loop and the extreme vertices.
  task automatic test_insert_and_walk();
    write_vertex_count(7'd64);
    send_item(MODE_ADD, 6'd0, 6'd1);
    send_item(MODE_ADD, 6'd0, 6'd2);
    send_item(MODE_ADD, 6'd1, 6'd3);
    send_item(MODE_ADD, 6'd2, 6'd3);
    send_item(MODE_ADD, 6'd3, 6'd0);
    send_item(MODE_ADD, 6'd63, 6'd62);
    send_item(MODE_ADD, 6'd62, 6'd63);
    send_item(MODE_ADD, 6'd10, 6'd10);
    send_item(MODE_WALK, 6'd0, 6'd63);
    send_item(MODE_WALK, 6'd63, 6'd0);
    // Vertex with no neighbors: one visit, flagged last.
    send_item(MODE_WALK, 6'd5, 6'd0);
  endtask

  // Out-of-range endpoints, bad start, shrunk count, zero and oversized counts.
  task automatic test_vertex_range();
    write_vertex_count(7'd4);
    send_item(MODE_ADD, 6'd4, 6'd0);
    send_item(MODE_ADD, 6'd0, 6'd4);
    send_item(MODE_ADD, 6'd3, 6'd1);
    send_item(MODE_WALK, 6'd4, 6'd0);
    send_item(MODE_WALK, 6'd0, 6'd0);
    write_vertex_count(7'd0);
    send_item(MODE_ADD, 6'd0, 6'd0);
    send_item(MODE_WALK, 6'd0, 6'd0);
    write_vertex_count(7'd127);
    send_item(MODE_WALK, 6'd62, 6'd0);
    send_item(MODE_ADD, 6'd63, 6'd0);
    send_item(MODE_WALK, 6'd63, 6'd0);
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] counts [6] = '{7'd1, 7'd64, 7'd7, 7'd33, 7'd127, 7'd16};
    for (int p = 0; p < 6; p++) begin
      write_vertex_count(counts[p]);
      // Run one phase back to back on both sides.
      no_idle = (p == 1);
      repeat (25) send_random_item();
    end
    no_idle = 1'b0;
  endtask

  // Hold the receiver off while walks keep arriving so the input backs up.
  task automatic test_output_backpressure();
    write_vertex_count(7'd64);
    hold_off_left = HOLD_CYCLES;
    for (int i = 0; i < 16; i++) begin
      if (i % 2 == 0)
        send_item(MODE_WALK, VTX_W'($urandom_range(0, 63)), VTX_W'($urandom_range(0, 63)));
      else
        send_item(MODE_ADD, VTX_W'($urandom_range(0, 63)), VTX_W'($urandom_range(0, 63)));
    end
  endtask

  // Fill the edge store, push past it, then walk the dense graph.
  task automatic test_store_full();
    write_vertex_count(7'd64);
    while (edge_total < MAX_EDGES)
      send_item(MODE_ADD, VTX_W'($urandom_range(0, 63)), VTX_W'($urandom_range(0, 63)));
    repeat (6)
      send_item(MODE_ADD, VTX_W'($urandom_range(0, 63)), VTX_W'($urandom_range(0, 63)));
    repeat (5)
      send_item(MODE_WALK, VTX_W'($urandom_range(0, 63)), VTX_W'($urandom_range(0, 63)));
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_num_vertices = NV_RESET;
    in_valid         = 1'b0;
    in_mode          = MODE_ADD;
    in_src_vertex    = '0;
    in_dst_vertex    = '0;
    no_idle          = 1'b0;
    hold_off_left    = 0;
    fail_count       = 0;
    edge_total       = 0;
    vertex_count_cfg = NV_RESET;
    foreach (edge_head[i]) edge_head[i] = 9'(MAX_EDGES);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_insert_and_walk();
    test_vertex_range();
    test_random_traffic();
    test_output_backpressure();
    test_store_full();
    wait_quiet();

    if (fail_count == 0 && expected_visits.size() == 0) begin
      $display("graph_depth_first_walk_top: match");
    end else begin
      $display("graph_depth_first_walk_top: mismatch");
    end
    $finish;
  end

endmodule
